// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions clocked on clk, with or without a disable in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every rising edge of clk while rst is low.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks prop at every rising edge of clk, also during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/ptaac_pkg.sv
// ----------------------------------------------------------------------------
// ptaac_pkg
// Types and fixed widths shared by the access counter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ptaac_pkg;

  localparam int ADDR_W  = 32;
  localparam int TID_W   = 4;
  localparam int COUNT_W = 32;
  localparam int INDEX_W = 6;
  // Wide enough to compare a thread number or sweep position with THREADS.
  localparam int TCMP_W  = 7;

  typedef struct packed {
    logic load_in;
    logic cmp;
    logic enc;
    logic adr;
    logic rd;
    logic wb;
    logic clr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic drop;
    logic clr_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// File: design/ptaac_ram.sv
// ----------------------------------------------------------------------------
// ptaac_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ptaac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 768,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// File: design/ptaac_ctrl.sv
// ----------------------------------------------------------------------------
// ptaac_ctrl
// Sequencer for one access: compare, encode, then counter update, allocation
// sweep or nothing (dropped access), then hand-off to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptaac_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ptaac_pkg::status_t status,
  output ptaac_pkg::cmd_t    cmd
);

  import ptaac_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_ENC,
    S_ADR,
    S_RD,
    S_WB,
    S_CLR,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = S_ENC;
      end
      S_ENC: begin
        cmd.enc    = 1'b1;
        state_next = S_ADR;
      end
      S_ADR: begin
        cmd.adr = 1'b1;
        if (status.drop) begin
          state_next = S_OUT;
        end else if (status.hit) begin
          state_next = S_RD;
        end else begin
          state_next = S_CLR;
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_WB;
      end
      S_WB: begin
        cmd.wb     = 1'b1;
        state_next = S_OUT;
      end
      S_CLR: begin
        cmd.clr = 1'b1;
        if (status.clr_last) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        cmd.out_load = status.out_free;
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: design/ptaac_dp.sv
// ----------------------------------------------------------------------------
// ptaac_dp
// Datapath: address tag store with parallel compare, fill count, counter
// memory with saturating update, allocation sweep and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptaac_dp #(
  parameter int ENTRIES = 64,
  parameter int THREADS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ptaac_pkg::cmd_t                 cmd,
  output ptaac_pkg::status_t              status,
  input  logic [ptaac_pkg::ADDR_W-1:0]    addr,
  input  logic [ptaac_pkg::TID_W-1:0]     tid,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            hit,
  output logic [ptaac_pkg::COUNT_W-1:0]   new_count,
  output logic [ptaac_pkg::INDEX_W-1:0]   entry_index,
  output logic                            dropped
);

  import ptaac_pkg::*;

  localparam int EW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int UW    = $clog2(ENTRIES + 1);
  localparam int DEPTH = ENTRIES * THREADS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KW    = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int PW    = EW + TCMP_W;

  logic [ADDR_W-1:0]  addr_q;
  logic [TID_W-1:0]   tid_q;
  logic [ADDR_W-1:0]  tag [ENTRIES];
  logic [UW-1:0]      used;
  logic [ENTRIES-1:0] match_c;
  logic [ENTRIES-1:0] match_q;
  logic [EW-1:0]      idx_c;
  logic [EW-1:0]      idx_q;
  logic               hit_q;
  logic               drop_c;
  logic               drop_q;
  logic [AW-1:0]      base_q;
  logic [PW-1:0]      base_prod;
  logic [KW-1:0]      sweep;
  logic [COUNT_W-1:0] count_q;
  logic [COUNT_W-1:0] sat_count;
  logic [COUNT_W-1:0] clr_data;
  logic [COUNT_W-1:0] ram_rdata;
  logic [COUNT_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_addr;
  logic               ram_we;
  logic               clr_last;

  // Slots fill in order, so a slot is live exactly when it is below the count.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_c[i] = (UW'(i) < used) && (tag[i] == addr_q);
    end
  end

  // Addresses are distinct, so at most one bit of match_q is set.
  always_comb begin
    idx_c = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_q[i]) begin
        idx_c = idx_c | EW'(i);
      end
    end
  end

  assign drop_c = (TCMP_W'(tid_q) >= TCMP_W'(THREADS)) ||
                  (!hit_q && (used == UW'(ENTRIES)));

  assign base_prod = PW'(idx_q) * PW'(THREADS);
  assign clr_last  = (TCMP_W'(sweep) == TCMP_W'(THREADS - 1));

  assign sat_count = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_W'(1);
  assign clr_data  = (TCMP_W'(sweep) == TCMP_W'(tid_q)) ? COUNT_W'(1) : '0;

  assign ram_we    = cmd.clr || cmd.wb;
  assign ram_wdata = cmd.wb ? sat_count : clr_data;
  assign ram_addr  = base_q + (cmd.clr ? AW'(sweep) : AW'(tid_q));

  ptaac_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (DEPTH)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign status.hit      = hit_q;
  assign status.drop     = drop_c;
  assign status.clr_last = clr_last;
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      addr_q <= addr;
      tid_q  <= tid;
    end
    if (cmd.cmp) begin
      match_q <= match_c;
    end
    if (cmd.enc) begin
      hit_q <= |match_q;
      idx_q <= (|match_q) ? idx_c : EW'(used);
    end
    if (cmd.adr) begin
      base_q <= AW'(base_prod);
      drop_q <= drop_c;
      sweep  <= '0;
    end
    if (cmd.clr) begin
      sweep   <= sweep + KW'(1);
      count_q <= COUNT_W'(1);
      if (clr_last) begin
        tag[idx_q] <= addr_q;
      end
    end
    if (cmd.wb) begin
      count_q <= sat_count;
    end
    if (cmd.out_load) begin
      hit         <= hit_q && !drop_q;
      new_count   <= drop_q ? '0 : count_q;
      entry_index <= drop_q ? '0 : INDEX_W'(idx_q);
      dropped     <= drop_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr && clr_last) begin
        used <= used + UW'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/per_thread_address_access_counter.sv
// ----------------------------------------------------------------------------
// per_thread_address_access_counter
// Associative table of addresses, each with one saturating count per thread.
// ----------------------------------------------------------------------------
// Usage: each input item (addr, tid) is one traced access, taken on the
// in_valid/in_ready handshake. Each item yields exactly one result item
// (hit, new_count, entry_index, dropped) on out_valid/out_ready.
// A hit bumps that thread's count for the entry; a miss allocates the next
// free slot with the thread's count at 1; a full table or a thread number
// of THREADS or above drops the access and sets dropped.
// One item is in flight at a time. From acceptance to out_valid a hit goes
// through tag compare, index encode, address multiply, counter memory read,
// write-back and output load; a drop skips the read and write-back; a miss
// instead writes the THREADS counters of the new slot one per cycle through
// the single port of the counter memory. A new item is taken in the cycle
// after the output register is loaded, while the result may still wait.
// Reset empties the table at once by clearing the fill count; no sweep.
// A stalled receiver holds the result in the output register and stops the
// block only when the next result is ready to be loaded.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module per_thread_address_access_counter #(
  parameter int ENTRIES = 64,
  parameter int THREADS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ptaac_pkg::ADDR_W-1:0]    addr,
  input  logic [ptaac_pkg::TID_W-1:0]     tid,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            hit,
  output logic [ptaac_pkg::COUNT_W-1:0]   new_count,
  output logic [ptaac_pkg::INDEX_W-1:0]   entry_index,
  output logic                            dropped
);

  import ptaac_pkg::*;

  cmd_t    cmd;
  status_t status;

  ptaac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ptaac_dp #(
    .ENTRIES (ENTRIES),
    .THREADS (THREADS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .addr        (addr),
    .tid         (tid),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .new_count   (new_count),
    .entry_index (entry_index),
    .dropped     (dropped)
  );

  `ASSERT_CLK(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "accepted item while busy")
  `ASSERT_CLK(a_out_from_load, $rose(out_valid) |-> $past(cmd.out_load), "result without load")
  `ASSERT_CLK(a_drop_zero, out_valid && dropped |-> !hit && new_count == '0 && entry_index == '0, "dropped result not cleared")
  `ASSERT_CLK(a_alloc_one, out_valid && !hit && !dropped |-> new_count == 32'd1, "new entry count not one")

endmodule

`default_nettype wire

// File: bench/tb_per_thread_address_access_counter.sv
// ----------------------------------------------------------------------------
// tb_per_thread_address_access_counter
// Self-checking bench for the per-thread address access counter.
// ----------------------------------------------------------------------------
// Traced accesses go in over a valid/ready channel. A behavioral copy of the
// address table predicts the hit flag, count, slot and drop flag of every
// accepted item, and each result is checked against it in order. Directed
// accesses come first, then random traffic over a growing pool of hot
// addresses under three idling mixes, then a table-full test, then a long
// receiver hold-off that backs the block up.
// Counter saturation needs about four billion hits on one counter. A run
// this short cannot reach it, but the predictor still models it.
// ----------------------------------------------------------------------------
module tb_per_thread_address_access_counter;
  timeunit 1ns;
  timeprecision 1ps;

  import ptaac_pkg::*;

  localparam int SLOTS       = 64;
  localparam int THREAD_CNT  = 12;
  localparam int POOL_SIZE   = 80;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 40;
  localparam int ITEMS_PER_PHASE = 385;

  typedef struct packed {
    logic               hit;
    logic [COUNT_W-1:0] count;
    logic [INDEX_W-1:0] index;
    logic               dropped;
  } access_outcome_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [ADDR_W-1:0]  addr = '0;
  logic [TID_W-1:0]   tid = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               hit;
  logic [COUNT_W-1:0] new_count;
  logic [INDEX_W-1:0] entry_index;
  logic               dropped;

  // Behavioral copy of the table.
  logic               slot_valid [SLOTS];
  logic [ADDR_W-1:0]  slot_addr  [SLOTS];
  logic [COUNT_W-1:0] slot_count [SLOTS][THREAD_CNT];
  int                 slots_used;

  access_outcome_t outcome_queue[$];
  access_outcome_t checker_want;
  logic [ADDR_W-1:0] hot_addrs [POOL_SIZE];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holds_asked   = 0;
  int holds_started = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int random_items  = 0;

  int mismatch_count  = 0;
  int results_checked = 0;
  int n_hits          = 0;
  int n_allocs        = 0;
  int n_full_drops    = 0;
  int n_bad_thread    = 0;

  per_thread_address_access_counter #(
    .ENTRIES(SLOTS),
    .THREADS(THREAD_CNT)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .addr       (addr),
    .tid        (tid),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hit        (hit),
    .new_count  (new_count),
    .entry_index(entry_index),
    .dropped    (dropped)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Applies one access to the table copy and returns what the block reports.
  function automatic access_outcome_t account_access(input logic [ADDR_W-1:0] a,
                                                      input logic [TID_W-1:0] t);
    access_outcome_t r;
    r = '0;
    if (int'(t) >= THREAD_CNT) begin
      r.dropped = 1'b1;
      n_bad_thread++;
      return r;
    end
    for (int s = 0; s < SLOTS; s++) begin
      if (slot_valid[s] && slot_addr[s] == a) begin
        if (slot_count[s][t] != '1)
          slot_count[s][t] = slot_count[s][t] + 1'b1;
        r.hit   = 1'b1;
        r.count = slot_count[s][t];
        r.index = s[INDEX_W-1:0];
        n_hits++;
        return r;
      end
    end
    if (slots_used >= SLOTS) begin
      r.dropped = 1'b1;
      n_full_drops++;
      return r;
    end
    slot_valid[slots_used] = 1'b1;
    slot_addr[slots_used]  = a;
    for (int k = 0; k < THREAD_CNT; k++)
      slot_count[slots_used][k] = '0;
    slot_count[slots_used][t] = 1;
    r.count = 1;
    r.index = slots_used[INDEX_W-1:0];
    slots_used++;
    n_allocs++;
    return r;
  endfunction

  // Offers one item from a falling edge and returns once it is accepted.
  // Valid is left high so that a back-to-back item needs no extra edge.
  task automatic send_access(input logic [ADDR_W-1:0] a, input logic [TID_W-1:0] t);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    addr     <= a;
    tid      <= t;
    do @(posedge clk); while (!in_ready);
    outcome_queue.push_back(account_access(a, t));
  endtask

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (holds_started != holds_asked) begin
      holds_started++;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (outcome_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: result with nothing pending: hit=%0b count=%0d index=%0d drop=%0b",
                   hit, new_count, entry_index, dropped);
      end else begin
        checker_want = outcome_queue.pop_front();
        results_checked++;
        if (hit !== checker_want.hit || new_count !== checker_want.count ||
            entry_index !== checker_want.index || dropped !== checker_want.dropped) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: result %0d: want hit=%0b count=%0d index=%0d drop=%0b, got hit=%0b count=%0d index=%0d drop=%0b",
                     results_checked, checker_want.hit, checker_want.count,
                     checker_want.index, checker_want.dropped,
                     hit, new_count, entry_index, dropped);
        end
      end
    end
  end

  // Ends the run if neither channel moves an item for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles, %0d results pending.",
                 QUIET_LIMIT, outcome_queue.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic test_directed_cases();
    send_idle_pct = 17;
    recv_idle_pct = 60;
    // Thread numbers at or above the thread count are ignored outright.
    send_access('0, 4'd12);
    send_access('1, 4'd15);
    send_access('0, 4'd0);
    send_access('0, 4'd0);
    send_access('0, 4'd11);
    send_access('1, 4'd11);
    send_access('1, 4'd5);
    // A bad thread number is ignored even when the address is present.
    send_access('0, 4'd13);
    send_access('1, 4'd14);
    send_access(32'h8000_0000, 4'd0);
    send_access(32'h0000_0001, 4'd7);
    send_access(32'h7FFF_FFFF, 4'd10);
    send_access('0, 4'd0);
    send_access(32'h8000_0000, 4'd0);
    send_access(32'h5555_5555, 4'd3);
    send_access(32'hAAAA_AAAA, 4'd8);
    send_access(32'h5555_5555, 4'd3);
    send_access('1, 4'd11);
  endtask

  // Mostly hits and fills over a pool that widens as the run goes on, with
  // fresh addresses and bad thread numbers mixed in.
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int n_items);
    int done;
    int roll;
    int reach;
    done = 0;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (done < n_items) begin
      roll  = $urandom_range(0, 99);
      reach = 3 + random_items / 12;
      if (reach > POOL_SIZE - 1)
        reach = POOL_SIZE - 1;
      if (roll < 8) begin
        send_access(roll[0] ? $urandom() : hot_addrs[$urandom_range(0, reach)],
                    TID_W'($urandom_range(THREAD_CNT, 15)));
      end else begin
        send_access(roll < 18 ? $urandom() : hot_addrs[$urandom_range(0, reach)],
                    TID_W'($urandom_range(0, THREAD_CNT - 1)));
        done++;
        random_items++;
      end
    end
  endtask

  task automatic test_full_table();
    send_idle_pct = 17;
    recv_idle_pct = 17;
    while (slots_used < SLOTS)
      send_access($urandom(), TID_W'($urandom_range(0, THREAD_CNT - 1)));
    repeat (6)
      send_access($urandom(), TID_W'($urandom_range(0, THREAD_CNT - 1)));
    send_access(slot_addr[SLOTS - 1], 4'd11);
    send_access(slot_addr[0], 4'd0);
    send_access($urandom(), 4'd12);
  endtask

  // The receiver stalls for a long stretch while items keep coming, so the
  // output register fills and the block stops taking input.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    holds_asked++;
    repeat (20)
      send_access(hot_addrs[$urandom_range(0, POOL_SIZE - 1)],
                  TID_W'($urandom_range(0, THREAD_CNT - 1)));
  endtask

  initial begin
    for (int s = 0; s < SLOTS; s++)
      slot_valid[s] = 1'b0;
    slots_used = 0;
    for (int p = 0; p < POOL_SIZE; p++)
      hot_addrs[p] = $urandom();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_random_traffic(17, 60, ITEMS_PER_PHASE);
    test_random_traffic(60, 17, ITEMS_PER_PHASE);
    test_random_traffic(0, 0, ITEMS_PER_PHASE);
    test_full_table();
    test_output_backpressure();

    @(negedge clk);
    in_valid <= 1'b0;
    while (outcome_queue.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d results: %0d hits, %0d new slots, %0d misses on a full table,",
             results_checked, n_hits, n_allocs, n_full_drops);
    $display("%0d accesses with a bad thread number, %0d of %0d slots in use, %0d mismatches.",
             n_bad_thread, slots_used, SLOTS, mismatch_count);
    if (mismatch_count == 0 && outcome_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
